// ----- rtl/pdf_pkg.sv -----
// ---------------------------------------------------------------------------
// pdf_pkg - shared definitions for the pareto dominance filter
// Field widths, register reset value and the token control word that moves
// down the chain of compare cells.
// ---------------------------------------------------------------------------
package pdf_pkg;

   localparam int COORD_W        = 32;
   localparam int POINT_INDEX_W  = 6;
   localparam int NUM_DIMS_W     = 4;
   // one bit more than the register so a dimension count up to 16 fits
   localparam int DIM_W          = NUM_DIMS_W + 1;
   localparam int RSP_DATA_W     = 8;
   localparam logic [NUM_DIMS_W-1:0] NUM_DIMS_RESET = 4'd2;

   localparam int MAX_POINTS_DEF = 64;
   localparam int MAX_DIMS_DEF   = 8;

   // control bits of one coordinate token
   typedef struct packed {
      logic valid;
      logic first;   // first coordinate of the source point
      logic last;    // last coordinate of the source point
   } tok_ctl_type;

endpackage

// ----- rtl/pdf_cell.sv -----
// ---------------------------------------------------------------------------
// pdf_cell - one point of the compare chain
// Holds the coordinates of one stored point, compares each passing token
// against its own coordinate and marks itself when the source point
// dominates it. Tokens are registered and handed to the next cell.
// ---------------------------------------------------------------------------
module pdf_cell #(
   parameter int MAX_DIMS = pdf_pkg::MAX_DIMS_DEF,
   parameter int K_W      = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear_marks,
   input  logic                       wr_en,
   input  logic [K_W-1:0]             wr_k,
   input  logic [pdf_pkg::COORD_W-1:0] wr_data,
   input  logic                       active,
   input  pdf_pkg::tok_ctl_type       in_ctl,
   input  logic [K_W-1:0]             in_k,
   input  logic [pdf_pkg::COORD_W-1:0] in_data,
   output pdf_pkg::tok_ctl_type       out_ctl,
   output logic [K_W-1:0]             out_k,
   output logic [pdf_pkg::COORD_W-1:0] out_data,
   output logic                       mark
);

   logic [pdf_pkg::COORD_W-1:0] coord_ff [MAX_DIMS];
   logic [pdf_pkg::COORD_W-1:0] own;
   logic                        in_lt, in_gt;
   logic                        src_better_in, own_better_in;
   logic                        src_better_ff, own_better_ff;
   logic                        mark_ff, mark_in;
   pdf_pkg::tok_ctl_type        ctl_ff;
   logic [K_W-1:0]              k_ff;
   logic [pdf_pkg::COORD_W-1:0] data_ff;

   always_comb begin
      own   = coord_ff[in_k];
      in_lt = $signed(in_data) < $signed(own);
      in_gt = $signed(own) < $signed(in_data);
      if (in_ctl.first) begin
         src_better_in = in_lt;
         own_better_in = in_gt;
      end else begin
         src_better_in = src_better_ff | in_lt;
         own_better_in = own_better_ff | in_gt;
      end
      mark_in = mark_ff;
      // a point never dominates itself: equal coordinates give no better side
      if (in_ctl.valid && in_ctl.last && active && src_better_in && !own_better_in) begin
         mark_in = 1'b1;
      end
      if (clear_marks) begin
         mark_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coord_ff[wr_k] <= wr_data;
      end
      if (in_ctl.valid) begin
         src_better_ff <= src_better_in;
         own_better_ff <= own_better_in;
      end
      k_ff    <= in_k;
      data_ff <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
         ctl_ff  <= '0;
      end else begin
         mark_ff <= mark_in;
         ctl_ff  <= in_ctl;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_k    = k_ff;
   assign out_data = data_ff;
   assign mark     = mark_ff;

endmodule

// ----- rtl/pareto_dominance_filter_top.sv -----
// ---------------------------------------------------------------------------
// pareto_dominance_filter_top - marks dominated points of a set
// Loads one coordinate per cycle while in the load state; at the end of a set
// every stored point is streamed through a chain of compare cells, then one result per point goes out.
// ---------------------------------------------------------------------------
// load: one coordinate item per cycle while req_tready is high
// compare: the point store is streamed token by token, then the drain state waits
//   for the last token to clear the cell chain
// output: one result per cycle unless rsp_tready stalls; next set loads while the last result waits
// reset clears counters, marks and the dimension register (2); store not cleared
module pareto_dominance_filter_top #(
   parameter int MAX_POINTS = pdf_pkg::MAX_POINTS_DEF,
   parameter int MAX_DIMS   = pdf_pkg::MAX_DIMS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pdf_pkg::COORD_W-1:0]     req_tdata,  // coordinate
   input  logic                            req_tlast,  // last_in_set
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pdf_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // point_index[5:0], dominated, overflow
   output logic                            rsp_tlast,  // last_point
   input  logic                            csr_wr_en,
   input  logic [pdf_pkg::NUM_DIMS_W-1:0]  csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int K_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int MEM_DEPTH = MAX_POINTS * (2 ** K_W);
   localparam int DIM_W = pdf_pkg::DIM_W;

   typedef enum logic [3:0] {
      S_LOAD    = 4'b0001,
      S_COMPARE = 4'b0010,
      S_DRAIN   = 4'b0100,
      S_OUTPUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [pdf_pkg::NUM_DIMS_W-1:0] num_dims_ff;
   logic [DIM_W-1:0]               dims;
   logic [DIM_W-1:0]               nd_ext;

   logic [CNT_W-1:0] point_count_ff, point_count_in;
   logic [K_W-1:0]   coord_count_ff, coord_count_in;
   logic             overflow_ff, overflow_in;
   logic [IDX_W-1:0] feed_pt_ff, feed_pt_in;
   logic [K_W-1:0]   feed_k_ff, feed_k_in;
   logic [CNT_W-1:0] drain_ff, drain_in;
   logic [IDX_W-1:0] out_idx_ff, out_idx_in;

   logic             req_accept, store_wr, point_done, clear_marks;
   logic             feed_last_k, feed_last_pt, out_last, rsp_load;

   logic [pdf_pkg::COORD_W-1:0] mem [MEM_DEPTH];
   logic [pdf_pkg::COORD_W-1:0] rd_data_ff;
   pdf_pkg::tok_ctl_type        tok_ctl_ff, tok_ctl_in;
   logic [K_W-1:0]              tok_k_ff;

   pdf_pkg::tok_ctl_type        chain_ctl  [MAX_POINTS+1];
   logic [K_W-1:0]              chain_k    [MAX_POINTS+1];
   logic [pdf_pkg::COORD_W-1:0] chain_data [MAX_POINTS+1];
   logic [MAX_POINTS-1:0]       mark_vec;
   logic [MAX_POINTS-1:0]       cell_wr;
   logic [MAX_POINTS-1:0]       cell_active;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pdf_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                           rsp_last_ff;

   // dimension count clamped to 1..MAX_DIMS
   always_comb begin
      nd_ext = {1'b0, num_dims_ff};
      if (num_dims_ff == '0) begin
         dims = DIM_W'(1);
      end else if (nd_ext > DIM_W'(MAX_DIMS)) begin
         dims = DIM_W'(MAX_DIMS);
      end else begin
         dims = nd_ext;
      end
   end

   assign req_tready   = (state_ff == S_LOAD);
   assign req_accept   = req_tvalid && req_tready;
   assign store_wr     = req_accept && (point_count_ff < CNT_W'(MAX_POINTS));
   assign point_done   = (DIM_W'(coord_count_ff) + DIM_W'(1)) >= dims;
   assign feed_last_k  = (DIM_W'(feed_k_ff) == dims - DIM_W'(1));
   assign feed_last_pt = (CNT_W'(feed_pt_ff) == point_count_ff - CNT_W'(1));
   assign out_last     = (CNT_W'(out_idx_ff) == point_count_ff - CNT_W'(1));
   assign rsp_load     = (state_ff == S_OUTPUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in       = state_ff;
      point_count_in = point_count_ff;
      coord_count_in = coord_count_ff;
      overflow_in    = overflow_ff;
      feed_pt_in     = feed_pt_ff;
      feed_k_in      = feed_k_ff;
      drain_in       = drain_ff;
      out_idx_in     = out_idx_ff;
      tok_ctl_in     = '0;
      clear_marks    = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               if (point_done) begin
                  coord_count_in = '0;
                  if (point_count_ff < CNT_W'(MAX_POINTS)) begin
                     point_count_in = point_count_ff + CNT_W'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else begin
                  coord_count_in = coord_count_ff + K_W'(1);
               end
               if (req_tlast) begin
                  coord_count_in = '0;
                  feed_pt_in     = '0;
                  feed_k_in      = '0;
                  out_idx_in     = '0;
                  if (point_count_in == '0) begin
                     // empty set: nothing to report
                     overflow_in = 1'b0;
                     clear_marks = 1'b1;
                  end else begin
                     state_in = S_COMPARE;
                  end
               end
            end
         end
         S_COMPARE: begin
            tok_ctl_in.valid = 1'b1;
            tok_ctl_in.first = (feed_k_ff == '0);
            tok_ctl_in.last  = feed_last_k;
            if (feed_last_k) begin
               feed_k_in  = '0;
               feed_pt_in = feed_pt_ff + IDX_W'(1);
               if (feed_last_pt) begin
                  drain_in = CNT_W'(MAX_POINTS);
                  state_in = S_DRAIN;
               end
            end else begin
               feed_k_in = feed_k_ff + K_W'(1);
            end
         end
         S_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = S_OUTPUT;
            end else begin
               drain_in = drain_ff - CNT_W'(1);
            end
         end
         S_OUTPUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               if (out_last) begin
                  point_count_in = '0;
                  overflow_in    = 1'b0;
                  clear_marks    = 1'b1;
                  state_in       = S_LOAD;
               end else begin
                  out_idx_in = out_idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_LOAD;
         num_dims_ff    <= pdf_pkg::NUM_DIMS_RESET;
         point_count_ff <= '0;
         coord_count_ff <= '0;
         overflow_ff    <= 1'b0;
         feed_pt_ff     <= '0;
         feed_k_ff      <= '0;
         drain_ff       <= '0;
         out_idx_ff     <= '0;
         tok_ctl_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         if (csr_wr_en) begin
            num_dims_ff <= csr_wr_data;
         end
         point_count_ff <= point_count_in;
         coord_count_ff <= coord_count_in;
         overflow_ff    <= overflow_in;
         feed_pt_ff     <= feed_pt_in;
         feed_k_ff      <= feed_k_in;
         drain_ff       <= drain_in;
         out_idx_ff     <= out_idx_in;
         tok_ctl_ff     <= tok_ctl_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // point store: written on load, read one coordinate a cycle during compare
   always_ff @(posedge clock) begin
      if (store_wr) begin
         mem[{point_count_ff[IDX_W-1:0], coord_count_ff}] <= req_tdata;
      end
      rd_data_ff <= mem[{feed_pt_ff, feed_k_ff}];
      tok_k_ff   <= feed_k_ff;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {overflow_ff, mark_vec[out_idx_ff],
                         pdf_pkg::POINT_INDEX_W'(out_idx_ff)};
         rsp_last_ff <= out_last;
      end
   end

   assign chain_ctl[0]  = tok_ctl_ff;
   assign chain_k[0]    = tok_k_ff;
   assign chain_data[0] = rd_data_ff;

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      assign cell_wr[i]     = store_wr && (point_count_ff[IDX_W-1:0] == IDX_W'(i));
      assign cell_active[i] = (CNT_W'(i) < point_count_ff);

      pdf_cell #(
         .MAX_DIMS (MAX_DIMS),
         .K_W      (K_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .clear_marks (clear_marks),
         .wr_en       (cell_wr[i]),
         .wr_k        (coord_count_ff),
         .wr_data     (req_tdata),
         .active      (cell_active[i]),
         .in_ctl      (chain_ctl[i]),
         .in_k        (chain_k[i]),
         .in_data     (chain_data[i]),
         .out_ctl     (chain_ctl[i+1]),
         .out_k       (chain_k[i+1]),
         .out_data    (chain_data[i+1]),
         .mark        (mark_vec[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- tb/sv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top - stream testbench for the pareto dominance filter
// Sends sets of points one coordinate per item and keeps its own copy of the
// point store and the dominance marks. Every result is checked, field by field,
// against the oldest verdict that is waiting. The run covers several dimension
// settings, partial and empty sets, and the overflow of the point store.
// Both sides of the stream stall at random, except in steady phases.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int MAX_P       = pdf_pkg::MAX_POINTS_DEF;
   localparam int MAX_D       = pdf_pkg::MAX_DIMS_DEF;
   // a full compare pass over the store plus the drain of the cell chain
   localparam int SETTLE      = MAX_P * MAX_D + MAX_P + 64;
   localparam int ITEM_TARGET = 430;

   typedef struct packed {
      logic [pdf_pkg::POINT_INDEX_W-1:0] point_index;
      logic                              dominated;
      logic                              last_point;
      logic                              overflow;
   } point_verdict_type;

   class dominance_scoreboard;
      logic [pdf_pkg::COORD_W-1:0]    coords [MAX_P][MAX_D];
      bit                             marks  [MAX_P];
      int unsigned                    n_points;
      int unsigned                    n_coords;
      bit                             overflow_seen;
      logic [pdf_pkg::NUM_DIMS_W-1:0] dims_reg = pdf_pkg::NUM_DIMS_RESET;
      point_verdict_type              verdict_q[$];
      int                             errors;

      function int unsigned active_dims();
         if (dims_reg == 0) return 1;
         if (dims_reg > MAX_D) return MAX_D;
         return dims_reg;
      endfunction

      function void note_coordinate(logic [pdf_pkg::COORD_W-1:0] c, bit last_in_set);
         int unsigned d;
         bit a_less;
         bit b_less;
         point_verdict_type v;
         d = active_dims();
         if (n_points < MAX_P && n_coords < MAX_D) coords[n_points][n_coords] = c;
         if (n_coords + 1 >= d) begin
            if (n_points < MAX_P) n_points++;
            else overflow_seen = 1'b1;
            n_coords = 0;
         end else begin
            n_coords++;
         end
         if (!last_in_set) return;

         // a point marked during the inner loop still keeps comparing
         for (int i = 0; i < n_points; i++) begin
            if (marks[i]) continue;
            for (int j = i + 1; j < n_points; j++) begin
               if (marks[j]) continue;
               a_less = 1'b0;
               b_less = 1'b0;
               for (int k = 0; k < d; k++) begin
                  if ($signed(coords[i][k]) < $signed(coords[j][k])) a_less = 1'b1;
                  else if ($signed(coords[j][k]) < $signed(coords[i][k])) b_less = 1'b1;
               end
               if (a_less && !b_less) marks[j] = 1'b1;
               else if (b_less && !a_less) marks[i] = 1'b1;
            end
         end

         for (int i = 0; i < n_points; i++) begin
            v.point_index = i[pdf_pkg::POINT_INDEX_W-1:0];
            v.dominated   = marks[i];
            v.last_point  = (i + 1 == n_points);
            v.overflow    = overflow_seen;
            verdict_q.push_back(v);
         end

         foreach (marks[i]) marks[i] = 1'b0;
         n_points      = 0;
         n_coords      = 0;
         overflow_seen = 1'b0;
      endfunction

      function void report(string field, int unsigned want, int unsigned got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_result(point_verdict_type got);
         point_verdict_type want;
         if (verdict_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            return;
         end
         want = verdict_q.pop_front();
         if (got.point_index !== want.point_index)
            report("point_index", want.point_index, got.point_index);
         if (got.dominated !== want.dominated)
            report("dominated", want.dominated, got.dominated);
         if (got.last_point !== want.last_point)
            report("last_point", want.last_point, got.last_point);
         if (got.overflow !== want.overflow)
            report("overflow", want.overflow, got.overflow);
      endfunction
   endclass

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [pdf_pkg::COORD_W-1:0]    req_tdata   = '0;
   logic                           req_tlast   = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [pdf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_wr_en   = 1'b0;
   logic [pdf_pkg::NUM_DIMS_W-1:0] csr_wr_data = '0;

   dominance_scoreboard sb = new;
   bit          steady;
   int unsigned items_sent;

   pareto_dominance_filter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // values read here are the ones the block saw at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result('{rsp_tdata[5:0], rsp_tdata[6], rsp_tlast, rsp_tdata[7]});
         if (req_tvalid && req_tready)
            sb.note_coordinate(req_tdata, req_tlast);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [pdf_pkg::COORD_W-1:0] pick_coordinate();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               default: return 32'h0000_0000;
            endcase
         end
         // a narrow range makes ties and dominance frequent
         default: return pdf_pkg::COORD_W'($signed($urandom_range(0, 6)) - 3);
      endcase
   endfunction

   always begin
      if (steady) begin
         rsp_tready <= 1'b1;
         @(posedge clock);
      end else begin
         int unsigned run;
         int unsigned gap;
         run = $urandom_range(1, 12);
         gap = pick_gap();
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic send_coordinate(input logic [pdf_pkg::COORD_W-1:0] c,
                                  input logic last_in_set);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last_in_set;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // full points, then extra coordinates; the set ends on the final item
   task automatic send_points(input int unsigned npts, input int unsigned tail);
      int unsigned total;
      total = npts * sb.active_dims() + tail;
      for (int unsigned t = 0; t < total; t++)
         send_coordinate(pick_coordinate(), t == total - 1);
   endtask

   task automatic drain_results(input int unsigned settle);
      req_tvalid <= 1'b0;
      // let the final item of the set be noted first
      @(posedge clock);
      while (sb.verdict_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_dims(input logic [pdf_pkg::NUM_DIMS_W-1:0] value);
      drain_results(SETTLE);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.dims_reg = value;
   endtask

   initial begin
      logic [pdf_pkg::NUM_DIMS_W-1:0] dims_plan [7];
      int unsigned phase;
      int unsigned phase_start;
      int unsigned kind;
      int unsigned d;

      dims_plan = '{4'd1, 4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd2};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two dimensions from reset: extremes, a mutual standoff, equal points
      send_coordinate(32'h8000_0000, 1'b0);
      send_coordinate(32'h7fff_ffff, 1'b0);
      send_coordinate(32'h7fff_ffff, 1'b0);
      send_coordinate(32'h8000_0000, 1'b0);
      send_coordinate(32'h0000_0000, 1'b0);
      send_coordinate(32'h0000_0000, 1'b0);
      send_coordinate(32'h0000_0000, 1'b0);
      send_coordinate(32'h0000_0000, 1'b0);
      send_coordinate(32'h0000_0001, 1'b0);
      send_coordinate(32'h0000_0001, 1'b1);
      // partial final point is dropped
      send_coordinate(32'h0000_0005, 1'b0);
      send_coordinate(32'hffff_ffff, 1'b0);
      send_coordinate(32'h0000_0003, 1'b1);
      // set that ends before any point is complete
      send_coordinate(32'h0000_0009, 1'b1);

      // zero acts as one dimension
      write_dims(4'd0);
      send_coordinate(32'h0000_0004, 1'b0);
      send_coordinate(32'hffff_fffe, 1'b0);
      send_coordinate(32'hffff_fffe, 1'b1);

      // values above the maximum act as the maximum
      write_dims(4'd15);
      for (int k = 0; k < MAX_D; k++)
         send_coordinate(pdf_pkg::COORD_W'(k * 3 - 7), k == MAX_D - 1);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         write_dims(phase < 7 ? dims_plan[phase]
                              : pdf_pkg::NUM_DIMS_W'($urandom_range(0, 15)));
         steady = ($urandom_range(0, 3) == 0);
         d = sb.active_dims();
         phase_start = items_sent;
         // more points than the store holds
         if (d == 1) send_points(MAX_P + 2 + $urandom_range(0, 3), 0);
         while (items_sent - phase_start < 50 && items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind < 8)
               send_points($urandom_range(1, kind == 0 ? 16 : 6), 0);
            else if (kind == 8)
               send_points($urandom_range(1, 5), d > 1 ? $urandom_range(1, d - 1) : 0);
            else
               send_points(0, $urandom_range(1, 3 * d));
            if ($urandom_range(0, 19) == 0) drain_results(0);
         end
         phase++;
      end

      steady = 1'b0;
      drain_results(SETTLE);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pdf_pkg.sv
rtl/pdf_cell.sv
rtl/pareto_dominance_filter_top.sv
tb/sv/tb_top.sv
